// ===== rtl/core/vmt_pkg.sv =====
package vmt_pkg;

  localparam int unsigned NCOMP      = 4;
  localparam int unsigned COMP_W     = 32;
  localparam int unsigned PROD_W     = 2 * COMP_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned ROW_SEL_W  = 2;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef comp_t [NCOMP-1:0]        vec_t;
  typedef sum_t  [NCOMP-1:0]        sumv_t;

  typedef struct packed {
    logic  vld;
    vec_t  v;
    sumv_t acc;
  } beat_t;

  typedef struct packed {
    logic                  we;
    logic                  half;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// ===== rtl/core/vertex_matrix_transform.sv =====
// Transforms one vertex (in_x, in_y, in_z, in_w) per beat by a 4x4 matrix.
// The vertex is a row vector and each output component is its dot product
// with one matrix column, in signed fixed point with FRAC_BITS fraction bits.
// The exact sum is floored and saturated to 32 bits, and out_saturated flags
// any clipped component.
// The input and output channels use valid and stall. The configuration port
// writes one 64-bit register per beat, two matrix entries of one row, and is
// always ready. Indices above seven are ignored. Write it only while idle.
// Four cells, one per matrix row, each add one row's products in two stages,
// and an output register follows. Beats pass each cell's product and sum
// registers, then the output register, one beat per cycle unless stalled.
// When the receiver stalls, the output register holds its beat and the
// cells keep filling their empty stages. in_stall rises only when every
// stage holds a beat. Reset empties the pipeline and loads the identity.
module vertex_matrix_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [vmt_pkg::COMP_W-1:0]  in_x,
  input  logic signed [vmt_pkg::COMP_W-1:0]  in_y,
  input  logic signed [vmt_pkg::COMP_W-1:0]  in_z,
  input  logic signed [vmt_pkg::COMP_W-1:0]  in_w,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [vmt_pkg::COMP_W-1:0]  out_x,
  output logic signed [vmt_pkg::COMP_W-1:0]  out_y,
  output logic signed [vmt_pkg::COMP_W-1:0]  out_z,
  output logic signed [vmt_pkg::COMP_W-1:0]  out_w,
  output logic                               out_saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vmt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vmt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vmt_pkg::*;

  beat_t   chain [NCOMP+1];
  logic    ready [NCOMP+1];
  cfg_wr_t cfg_wr [NCOMP];
  vec_t    res_vec;

  assign cfg_ready = 1'b1;

  assign chain[0].vld = in_valid;
  assign chain[0].v   = {in_w, in_z, in_y, in_x};
  assign chain[0].acc = '0;
  assign in_stall     = !ready[0];

  for (genvar i = 0; i < NCOMP; i++) begin : g_cell
    assign cfg_wr[i].we   = cfg_valid && cfg_ready &&
                            (cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(i));
    assign cfg_wr[i].half = cfg_index[0];
    assign cfg_wr[i].data = cfg_data;

    vmt_cell #(
      .ROW       (i),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg_wr   (cfg_wr[i]),
      .up_beat  (chain[i]),
      .up_ready (ready[i]),
      .dn_beat  (chain[i+1]),
      .dn_ready (ready[i+1])
    );
  end

  vmt_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_beat   (chain[NCOMP]),
    .up_ready  (ready[NCOMP]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_vec   (res_vec),
    .out_sat   (out_saturated)
  );

  assign out_x = res_vec[0];
  assign out_y = res_vec[1];
  assign out_z = res_vec[2];
  assign out_w = res_vec[3];

endmodule

// ===== rtl/core/vmt_cell.sv =====
module vmt_cell #(
  parameter int unsigned ROW       = 0,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vmt_pkg::cfg_wr_t cfg_wr,
  input  vmt_pkg::beat_t   up_beat,
  output logic             up_ready,
  output vmt_pkg::beat_t   dn_beat,
  input  logic             dn_ready
);
  import vmt_pkg::*;

  localparam comp_t ONE = comp_t'(1) << FRAC_BITS;

  comp_t m_r [NCOMP];

  logic  a_vld_r;
  vec_t  a_v_r;
  sumv_t a_acc_r;
  prod_t a_p_r [NCOMP];

  logic  b_vld_r;
  vec_t  b_v_r;
  sumv_t b_acc_r;

  logic  ready_a;
  logic  ready_b;
  prod_t prod_nxt [NCOMP];
  sumv_t sum_nxt;

  assign ready_b  = !b_vld_r || dn_ready;
  assign ready_a  = !a_vld_r || ready_b;
  assign up_ready = ready_a;

  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      prod_nxt[c] = prod_t'($signed(up_beat.v[ROW])) * prod_t'($signed(m_r[c]));
      sum_nxt[c]  = $signed(a_acc_r[c]) + sum_t'($signed(a_p_r[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCOMP; c++) begin
        m_r[c] <= (c == ROW) ? ONE : '0;
      end
    end else if (cfg_wr.we) begin
      if (!cfg_wr.half) begin
        m_r[0] <= cfg_wr.data[COMP_W-1:0];
        m_r[1] <= cfg_wr.data[CFG_DATA_W-1:COMP_W];
      end else begin
        m_r[2] <= cfg_wr.data[COMP_W-1:0];
        m_r[3] <= cfg_wr.data[CFG_DATA_W-1:COMP_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (ready_a) begin
        a_vld_r <= up_beat.vld;
      end
      if (ready_b) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && up_beat.vld) begin
      a_v_r   <= up_beat.v;
      a_acc_r <= up_beat.acc;
      for (int c = 0; c < NCOMP; c++) begin
        a_p_r[c] <= prod_nxt[c];
      end
    end
    if (ready_b && a_vld_r) begin
      b_v_r   <= a_v_r;
      b_acc_r <= sum_nxt;
    end
  end

  assign dn_beat.vld = b_vld_r;
  assign dn_beat.v   = b_v_r;
  assign dn_beat.acc = b_acc_r;

endmodule

// ===== rtl/core/vmt_sat.sv =====
module vmt_sat #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  vmt_pkg::beat_t up_beat,
  output logic           up_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output vmt_pkg::vec_t  out_vec,
  output logic           out_sat
);
  import vmt_pkg::*;

  logic out_valid_r;
  vec_t out_vec_r;
  logic out_sat_r;

  vec_t vec_nxt;
  logic sat_nxt;
  sum_t shifted;
  logic [SUM_W-COMP_W:0] top_bits;

  assign up_ready = !out_valid_r || !out_stall;

  always_comb begin
    sat_nxt  = 1'b0;
    shifted  = '0;
    top_bits = '0;
    for (int c = 0; c < NCOMP; c++) begin
      shifted  = $signed(up_beat.acc[c]) >>> FRAC_BITS;
      top_bits = shifted[SUM_W-1:COMP_W-1];
      if (top_bits == '0 || top_bits == '1) begin
        vec_nxt[c] = shifted[COMP_W-1:0];
      end else begin
        sat_nxt    = 1'b1;
        vec_nxt[c] = shifted[SUM_W-1] ? {1'b1, {(COMP_W-1){1'b0}}}
                                      : {1'b0, {(COMP_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_beat.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_beat.vld) begin
      out_vec_r <= vec_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_vec   = out_vec_r;
  assign out_sat   = out_sat_r;

endmodule

// ===== rtl/core/vmt_checker.sv =====
module vmt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [vmt_pkg::COMP_W-1:0]  out_x,
  input logic signed [vmt_pkg::COMP_W-1:0]  out_w,
  input logic                               out_saturated,
  input logic                               cfg_valid,
  input logic                               cfg_ready
);
  import vmt_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present right after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output is free");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration beat refused");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_w)
                                  && $stable(out_saturated)))
    else $error("stalled output beat changed");

endmodule

bind vertex_matrix_transform vmt_checker u_vmt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_x         (out_x),
  .out_w         (out_w),
  .out_saturated (out_saturated),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

// ===== dv/xform_checker.sv =====
`timescale 1ns / 100ps

module xform_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [vmt_pkg::COMP_W-1:0]  in_x,
  input  logic signed [vmt_pkg::COMP_W-1:0]  in_y,
  input  logic signed [vmt_pkg::COMP_W-1:0]  in_z,
  input  logic signed [vmt_pkg::COMP_W-1:0]  in_w,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [vmt_pkg::COMP_W-1:0]  out_x,
  input  logic signed [vmt_pkg::COMP_W-1:0]  out_y,
  input  logic signed [vmt_pkg::COMP_W-1:0]  out_z,
  input  logic signed [vmt_pkg::COMP_W-1:0]  out_w,
  input  logic                               out_saturated,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [vmt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vmt_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int unsigned                        pending,
  output int unsigned                        errors
);
  import vmt_pkg::*;

  localparam int unsigned MAT_REGS = 8;
  localparam sum_t COMP_MAX = sum_t'(comp_t'(32'h7FFFFFFF));
  localparam sum_t COMP_MIN = sum_t'(comp_t'(32'h80000000));

  typedef struct packed {
    vec_t v;
    logic sat;
  } xform_t;

  comp_t  mat [NCOMP][NCOMP];
  xform_t expected_q [$];

  function automatic void load_identity();
    int r;
    int c;
    for (r = 0; r < NCOMP; r++) begin
      for (c = 0; c < NCOMP; c++) begin
        mat[r][c] = (r == c) ? (comp_t'(1) <<< FRAC_BITS) : '0;
      end
    end
  endfunction

  function automatic xform_t transform_vertex(input vec_t v);
    xform_t res;
    sum_t   acc;
    int     i;
    int     j;
    res.sat = 1'b0;
    for (j = 0; j < NCOMP; j++) begin
      acc = '0;
      for (i = 0; i < NCOMP; i++) begin
        acc = acc + $signed(v[i]) * mat[i][j];
      end
      acc = acc >>> FRAC_BITS;
      if (acc > COMP_MAX) begin
        acc = COMP_MAX;
        res.sat = 1'b1;
      end else if (acc < COMP_MIN) begin
        acc = COMP_MIN;
        res.sat = 1'b1;
      end
      res.v[j] = comp_t'(acc);
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    xform_t want;
    vec_t   got;
    int     j;
    int     row;
    int     col;
    if (!rst_n) begin
      expected_q.delete();
      load_identity();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_w, out_z, out_y, out_x};
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with no vertex pending, x=%0d y=%0d z=%0d w=%0d",
                   $time, out_x, out_y, out_z, out_w);
        end else begin
          want = expected_q.pop_front();
          for (j = 0; j < NCOMP; j++) begin
            if (got[j] !== want.v[j]) begin
              errors++;
              $display("%0t: component %0d expected %0d got %0d",
                       $time, j, $signed(want.v[j]), $signed(got[j]));
            end
          end
          if (out_saturated !== want.sat) begin
            errors++;
            $display("%0t: saturated expected %0b got %0b", $time, want.sat, out_saturated);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(transform_vertex({in_w, in_z, in_y, in_x}));
      end
      if (cfg_valid && cfg_ready && cfg_index < MAT_REGS) begin
        row = cfg_index >> 1;
        col = (cfg_index & 1) * 2;
        mat[row][col]     = cfg_data[31:0];
        mat[row][col + 1] = cfg_data[63:32];
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import vmt_pkg::*;

  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned MAT_REGS       = 8;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 80;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned SQUEEZE_AT     = 300;
  localparam int unsigned SQUEEZE_CYCLES = 80;
  localparam int unsigned RX_QUIET_LO    = 120;
  localparam int unsigned RX_QUIET_HI    = 240;
  localparam int unsigned TX_QUIET_LO    = 400;
  localparam int unsigned TX_QUIET_HI    = 520;

  localparam comp_t C_MAX = 32'h7FFFFFFF;
  localparam comp_t C_MIN = 32'h80000000;
  localparam comp_t C_ONE = comp_t'(1) <<< FRAC_BITS;
  localparam comp_t C_NEG = -32'sd1;

  typedef vec_t [NCOMP-1:0] mat_t;

  typedef enum int {
    MK_SMALL,
    MK_FULL,
    MK_NEAR_ID,
    MK_EXTREME,
    MK_IDENTITY
  } matrix_kind_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  comp_t                 in_x          = '0;
  comp_t                 in_y          = '0;
  comp_t                 in_z          = '0;
  comp_t                 in_w          = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  comp_t                 out_x;
  comp_t                 out_y;
  comp_t                 out_z;
  comp_t                 out_w;
  logic                  out_saturated;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  int unsigned chk_pending;
  int unsigned chk_errors;
  int unsigned items_sent   = 0;
  int unsigned rx_beats     = 0;
  int unsigned squeeze_left = 0;
  logic        squeezed     = 1'b0;
  int unsigned cycles       = 0;

  vertex_matrix_transform #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  xform_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(chk_pending), .errors(chk_errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("vertex_matrix_transform test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      rx_beats <= rx_beats + 1;
    end
  end

  // Random stalls, a free stretch, and one long hold-off so the pipeline fills.
  always @(negedge clk) begin
    if (squeeze_left != 0) begin
      out_stall    <= 1'b1;
      squeeze_left <= squeeze_left - 1;
    end else if (!squeezed && rx_beats >= SQUEEZE_AT) begin
      squeezed     <= 1'b1;
      squeeze_left <= SQUEEZE_CYCLES - 1;
      out_stall    <= 1'b1;
    end else if (rx_beats >= RX_QUIET_LO && rx_beats < RX_QUIET_HI) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 25);
    end
  end

  task automatic send_vertex(input comp_t x, input comp_t y, input comp_t z, input comp_t w);
    if (items_sent < TX_QUIET_LO || items_sent >= TX_QUIET_HI) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    in_w     <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stray writes to unused indices are mixed in; they must leave the matrix alone.
  task automatic load_matrix(input mat_t m);
    int r;
    int p;
    for (r = 0; r < NCOMP; r++) begin
      for (p = 0; p < 2; p++) begin
        if ($urandom_range(99) < 20) begin
          cfg_write(CFG_IDX_W'(MAT_REGS + $urandom_range(0, (1 << CFG_IDX_W) - 1 - MAT_REGS)),
                    {$urandom, $urandom});
        end
        cfg_write(CFG_IDX_W'(2 * r + p), {m[r][2 * p + 1], m[r][2 * p]});
      end
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic mat_t uniform_matrix(input comp_t e);
    mat_t m;
    int   r;
    int   c;
    for (r = 0; r < NCOMP; r++) begin
      for (c = 0; c < NCOMP; c++) begin
        m[r][c] = e;
      end
    end
    return m;
  endfunction

  function automatic comp_t extreme_comp();
    case ($urandom_range(4))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return C_NEG;
      default: return C_ONE;
    endcase
  endfunction

  function automatic mat_t build_matrix(input matrix_kind_t kind);
    mat_t m;
    int   r;
    int   c;
    for (r = 0; r < NCOMP; r++) begin
      for (c = 0; c < NCOMP; c++) begin
        case (kind)
          MK_SMALL:   m[r][c] = comp_t'($urandom_range(0, 1 << 19)) - (comp_t'(1) <<< 18);
          MK_FULL:    m[r][c] = $urandom;
          MK_NEAR_ID: m[r][c] = ((r == c) ? C_ONE : comp_t'(0))
                                + comp_t'($urandom_range(0, 1 << 12)) - (comp_t'(1) <<< 11);
          MK_EXTREME: m[r][c] = extreme_comp();
          default:    m[r][c] = (r == c) ? C_ONE : comp_t'(0);
        endcase
      end
    end
    return m;
  endfunction

  function automatic comp_t rand_comp();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      return extreme_comp();
    end else if (pick < 55) begin
      return comp_t'($urandom_range(0, 1 << 25)) - (comp_t'(1) <<< 24);
    end
    return $urandom;
  endfunction

  initial begin
    int           ph;
    int           n;
    int           k;
    matrix_kind_t kind;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Identity after reset.
    send_vertex('0, '0, '0, '0);
    send_vertex(C_MAX, C_MAX, C_MAX, C_MAX);
    send_vertex(C_MIN, C_MIN, C_MIN, C_MIN);
    send_vertex(C_ONE, -C_ONE, C_MAX, C_MIN);
    send_vertex(C_NEG, comp_t'(1), C_NEG, comp_t'(1));

    // Writes to unused indices are ignored.
    drain();
    for (k = MAT_REGS; k < (1 << CFG_IDX_W); k++) begin
      cfg_write(CFG_IDX_W'(k), {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
    send_vertex(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0);

    drain();
    load_matrix(uniform_matrix(C_MAX));
    send_vertex(C_MAX, C_MAX, C_MAX, C_MAX);
    send_vertex(C_MIN, C_MIN, C_MIN, C_MIN);
    send_vertex(C_MAX, C_MIN, '0, '0);
    send_vertex(comp_t'(1), '0, '0, '0);

    // The largest sum the products can reach.
    drain();
    load_matrix(uniform_matrix(C_MIN));
    send_vertex(C_MIN, C_MIN, C_MIN, C_MIN);
    send_vertex(C_MAX, C_MAX, C_MAX, C_MAX);

    // Negative sums floor toward minus infinity.
    drain();
    load_matrix(uniform_matrix(C_NEG));
    send_vertex(comp_t'(1), '0, '0, '0);
    send_vertex(C_ONE, '0, '0, '0);
    send_vertex(C_ONE + comp_t'(1), '0, '0, '0);
    send_vertex(C_MIN, C_MIN, C_MIN, C_MIN);
    send_vertex(C_NEG, C_NEG, C_NEG, C_NEG);

    for (ph = 0; ph < PHASES; ph++) begin
      kind = (ph == PHASES - 1) ? MK_IDENTITY : matrix_kind_t'(ph % 4);
      drain();
      load_matrix(build_matrix(kind));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_vertex(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (chk_errors == 0) begin
      $display("vertex_matrix_transform test passed");
    end else begin
      $display("vertex_matrix_transform test failed");
    end
    $finish;
  end

endmodule
